// ----- rtl/core/dfir_pkg.sv -----
// shared constants, field layout, request codes and sequencer-to-mac control type
// for the direct-form fir filter; no dependencies
package dfir_pkg;

   // sizing of the filter
   localparam int MAX_TAPS     = 256;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;

   // fixed field and register widths
   localparam int REQ_TYPE_WIDTH   = 2;
   localparam int COEF_INDEX_WIDTH = 8;
   localparam int NUM_TAPS_WIDTH   = 9;
   localparam int GAIN_WIDTH       = 16;
   localparam int GAIN_FRAC        = 12;

   // derived widths
   localparam int ADDR_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
   localparam int OPA_W     = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;
   localparam int OPB_W     = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int ACC_W     = PROD_W + TAP_CNT_W + 2;

   // request beat layout
   localparam int SAMPLE_LSB   = 0;
   localparam int ADDEND_LSB   = SAMPLE_LSB + SAMPLE_WIDTH;
   localparam int INDEX_LSB    = ADDEND_LSB + SAMPLE_WIDTH;
   localparam int COEF_LSB     = INDEX_LSB + COEF_INDEX_WIDTH;
   localparam int REQ_FIELDS_W = COEF_LSB + COEF_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

   // register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = (NUM_TAPS_WIDTH > GAIN_WIDTH) ? NUM_TAPS_WIDTH : GAIN_WIDTH;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_TAPS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_GAIN = 1'd1;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(1 << GAIN_FRAC);

   // request kinds
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_FILTER = 2'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_LOAD   = 2'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_en;
   } mac_ctrl_type;

endpackage

// ----- rtl/core/dfir_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dfir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dfir_mac.sv -----
// shared signed multiplier with registered product and accumulator
// depends on dfir_pkg
module dfir_mac (
   input  logic                                clock,
   input  dfir_pkg::mac_ctrl_type              ctrl,
   input  logic signed [dfir_pkg::OPA_W-1:0]   op_a,
   input  logic signed [dfir_pkg::OPB_W-1:0]   op_b,
   input  logic signed [dfir_pkg::ACC_W-1:0]   acc_init,
   output logic signed [dfir_pkg::PROD_W-1:0]  product,
   output logic signed [dfir_pkg::ACC_W-1:0]   acc
);
   import dfir_pkg::*;

   logic signed [PROD_W-1:0] product_ff, product_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = acc_init;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_W'(product_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         product_ff <= product_in;
      end
      acc_ff <= acc_in;
   end

   assign product = product_ff;
   assign acc     = acc_ff;

endmodule

// ----- rtl/core/direct_form_fir_filter_unit.sv -----
// direct-form fir filter top level: sequencer, history and coefficient rams, shared mac
// depends on dfir_pkg, dfir_ram, dfir_mac
// filter beat with m taps: fir (m tap reads), drain, round, out; rsp_tvalid is raised from out
// m is num_taps capped at MAX_TAPS; one tap per cycle through the single mac
// zero taps: the addend is passed to the result; coefficient load, clear history: no result
// synchronous reset clears history valid bits, write pointer, control and configuration registers; no sweep
module direct_form_fir_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_in, addend, coef_index, coef_value (low bit up)
   input  logic [dfir_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type
   input  logic [dfir_pkg::REQ_TYPE_WIDTH-1:0]  req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // filtered_sample
   output logic [dfir_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // clipped
   output logic [0:0]                           rsp_tuser,
   // register write port
   input  logic                                 csr_wr_en,
   input  logic [dfir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfir_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dfir_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_FIR   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // saturation limits in accumulator and scaler widths
   localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
   localparam logic signed [PROD_W:0]  C_MAX = (PROD_W + 1)'((64'sd1 <<< (COEF_WIDTH - 1)) - 1);
   localparam logic signed [PROD_W:0]  C_MIN = -C_MAX - (PROD_W + 1)'(1);

   // request fields
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic signed [SAMPLE_WIDTH-1:0] req_addend;
   logic [COEF_INDEX_WIDTH-1:0]    req_coef_index;
   logic signed [COEF_WIDTH-1:0]   req_coef_value;
   logic                           req_accept;

   assign req_sample     = signed'(req_tdata[SAMPLE_LSB +: SAMPLE_WIDTH]);
   assign req_addend     = signed'(req_tdata[ADDEND_LSB +: SAMPLE_WIDTH]);
   assign req_coef_index = req_tdata[INDEX_LSB +: COEF_INDEX_WIDTH];
   assign req_coef_value = signed'(req_tdata[COEF_LSB +: COEF_WIDTH]);

   // control registers
   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [TAP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TAP_CNT_W-1:0]    taps_use_ff, taps_use_in;
   logic [MAX_TAPS-1:0]     hist_valid_ff, hist_valid_in;
   logic                    s1_ff, s1_in;       // ram data present this cycle
   logic                    s2_ff, s2_in;       // product present this cycle
   logic                    rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [NUM_TAPS_WIDTH-1:0]    taps_ff;
   logic signed [GAIN_WIDTH-1:0] gain_ff;

   // payload registers
   logic [ADDR_W-1:0]              idx_ff, idx_in;
   logic [SAMPLE_WIDTH-1:0]        res_ff, res_in;
   logic                           clip_ff, clip_in;
   logic [SAMPLE_WIDTH-1:0]        rsp_data_ff, rsp_data_in;
   logic                           rsp_clip_ff, rsp_clip_in;
   logic                           hist_rd_valid_ff;

   // ram ports
   logic                    hist_we, hist_re, coef_we, coef_re;
   logic [SAMPLE_WIDTH-1:0] hist_rd_data;
   logic [COEF_WIDTH-1:0]   coef_rd_data;
   logic [COEF_WIDTH-1:0]   coef_wr_data;

   // mac
   mac_ctrl_type             mac_ctrl;
   logic signed [OPA_W-1:0]  mac_op_a;
   logic signed [OPB_W-1:0]  mac_op_b;
   logic signed [ACC_W-1:0]  mac_acc_init;
   logic signed [PROD_W-1:0] mac_product;
   logic signed [ACC_W-1:0]  mac_acc;

   // derived
   logic [TAP_CNT_W-1:0]           taps_m;
   logic                           index_ok;
   logic [ADDR_W-1:0]              wr_ptr_next;
   logic [ADDR_W-1:0]              rd_ptr_prev;
   logic signed [SAMPLE_WIDTH-1:0] hist_sample;
   logic signed [ACC_W-1:0]        y_round, y_shift;
   logic signed [PROD_W:0]         c_round, c_shift;
   logic signed [COEF_WIDTH-1:0]   c_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // tap count in use, capped at the history depth
   assign taps_m = (32'(taps_ff) > 32'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS)
                                                  : TAP_CNT_W'(taps_ff);
   assign index_ok = (32'(req_coef_index) < 32'(MAX_TAPS));

   // circular pointer steps
   assign wr_ptr_next = (wr_ptr_ff == ADDR_W'(MAX_TAPS - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_prev = (rd_ptr_ff == '0) ? ADDR_W'(MAX_TAPS - 1) : rd_ptr_ff - 1'b1;

   // history entries cleared since the last write read as zero
   assign hist_sample = hist_rd_valid_ff ? signed'(hist_rd_data) : '0;

   // mac operands: request coefficient and gain register during a coefficient load, ram data during taps
   assign mac_op_a     = (state_ff == ST_IDLE) ? OPA_W'(req_coef_value) : OPA_W'(hist_sample);
   assign mac_op_b     = (state_ff == ST_IDLE) ? OPB_W'(gain_ff)
                                               : OPB_W'(signed'(coef_rd_data));
   assign mac_acc_init = ACC_W'(req_addend) <<< (COEF_WIDTH - 1);

   // final rounding: half up, floor shift, then saturate
   assign y_round = mac_acc + (ACC_W'(1) <<< (COEF_WIDTH - 2));
   assign y_shift = y_round >>> (COEF_WIDTH - 1);

   // coefficient scaling by the q4.12 gain
   assign c_round = (PROD_W + 1)'(mac_product) + ((PROD_W + 1)'(1) <<< (GAIN_FRAC - 1));
   assign c_shift = c_round >>> GAIN_FRAC;
   always_comb begin
      if (c_shift > C_MAX) begin
         c_sat = COEF_WIDTH'(C_MAX);
      end else if (c_shift < C_MIN) begin
         c_sat = COEF_WIDTH'(C_MIN);
      end else begin
         c_sat = COEF_WIDTH'(c_shift);
      end
   end
   assign coef_wr_data = c_sat;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      cnt_in        = cnt_ff;
      taps_use_in   = taps_use_ff;
      hist_valid_in = hist_valid_ff;
      s1_in         = 1'b0;
      s2_in         = s1_ff;
      idx_in        = idx_ff;
      res_in        = res_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_clip_in   = rsp_clip_ff;
      hist_we       = 1'b0;
      hist_re       = 1'b0;
      coef_we       = 1'b0;
      coef_re       = 1'b0;
      mac_ctrl          = '0;
      mac_ctrl.mul_en   = s1_ff;
      mac_ctrl.acc_en   = s2_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  REQ_FILTER: begin
                     if (taps_m == '0) begin
                        // pass addend straight through, history untouched
                        res_in   = req_addend;
                        clip_in  = 1'b0;
                        state_in = ST_OUT;
                     end else begin
                        hist_we                  = 1'b1;
                        hist_valid_in[wr_ptr_ff] = 1'b1;
                        rd_ptr_in                = wr_ptr_ff;
                        wr_ptr_in                = wr_ptr_next;
                        cnt_in                   = '0;
                        taps_use_in              = taps_m;
                        mac_ctrl.acc_load        = 1'b1;
                        state_in                 = ST_FIR;
                     end
                  end
                  REQ_LOAD: begin
                     if (index_ok) begin
                        mac_ctrl.mul_en = 1'b1;
                        idx_in          = ADDR_W'(req_coef_index);
                        hist_valid_in   = '0;
                        wr_ptr_in       = '0;
                        state_in        = ST_SCALE;
                     end
                  end
                  REQ_CLEAR: begin
                     hist_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCALE: begin
            coef_we  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FIR: begin
            // one tap read per cycle, newest sample first
            hist_re   = 1'b1;
            coef_re   = 1'b1;
            s1_in     = 1'b1;
            rd_ptr_in = rd_ptr_prev;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == taps_use_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (y_shift > Y_MAX) begin
               res_in  = SAMPLE_WIDTH'(Y_MAX);
               clip_in = 1'b1;
            end else if (y_shift < Y_MIN) begin
               res_in  = SAMPLE_WIDTH'(Y_MIN);
               clip_in = 1'b1;
            end else begin
               res_in  = SAMPLE_WIDTH'(y_shift);
               clip_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_clip_in  = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
         taps_use_ff   <= '0;
         hist_valid_ff <= '0;
         s1_ff         <= 1'b0;
         s2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
         taps_use_ff   <= taps_use_in;
         hist_valid_ff <= hist_valid_in;
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_TAPS:  taps_ff <= csr_wdata[NUM_TAPS_WIDTH-1:0];
            CSR_COEF_GAIN: gain_ff <= signed'(csr_wdata[GAIN_WIDTH-1:0]);
            default: begin
            end
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      res_ff           <= res_in;
      clip_ff          <= clip_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_clip_ff      <= rsp_clip_in;
      hist_rd_valid_ff <= hist_valid_ff[rd_ptr_ff];
   end

   // sample history
   dfir_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_sample),
      .rd_en   (hist_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (hist_rd_data)
   );

   // coefficient store, tap k at address k
   dfir_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (idx_ff),
      .wr_data (coef_wr_data),
      .rd_en   (coef_re),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (coef_rd_data)
   );

   // shared multiply-accumulate
   dfir_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_a     (mac_op_a),
      .op_b     (mac_op_b),
      .acc_init (mac_acc_init),
      .product  (mac_product),
      .acc      (mac_acc)
   );

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_clip_ff;

endmodule

// ----- rtl/core/dfir_checker.sv -----
// port-level checks for direct_form_fir_filter_unit and the bind that attaches them
// depends on dfir_pkg and the top level
module dfir_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [dfir_pkg::REQ_TYPE_WIDTH-1:0] req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dfir_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [0:0]                          rsp_tuser
);
   import dfir_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // filter and load beats keep the block busy, so ready is low in the cycle after they are taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_FILTER || req_tuser == REQ_LOAD)
      |=> !req_tready)
      else $error("ready right after a filter or load beat");

   // load, clear and unused beats produce no result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != REQ_FILTER && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result produced by a non-filter beat");

   // a clipped result sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0]
      |-> rsp_tdata[SAMPLE_WIDTH-1:0] == S_MAX || rsp_tdata[SAMPLE_WIDTH-1:0] == S_MIN)
      else $error("clipped result not saturated");

endmodule

bind direct_form_fir_filter_unit dfir_checker u_dfir_checker (.*);
